FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, ignored while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg
// Constants of the rational to binary32 converter.
// ----------------------------------------------------------------------------
package rtf_pkg;

  localparam int OPERAND_BITS_DEF = 32;
  localparam int FLOAT_W          = 32;
  localparam int EXP_W            = 8;
  localparam int FRAC_BITS        = 23;
  localparam int SIG_BITS         = FRAC_BITS + 1;
  // Significand bits plus one guard bit come out of the divider.
  localparam int QUO_BITS         = SIG_BITS + 1;
  localparam int CNT_W            = $clog2(QUO_BITS + 1);
  localparam int EXP_BIAS         = 127;

endpackage

FILE: hw/rtl/rational_to_float32_converter_top.sv
// ----------------------------------------------------------------------------
// rational_to_float32_converter_top
// Converts an unsigned numerator / denominator pair to the nearest binary32
// pattern, round to nearest even, with an exactness flag.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one beat holding the
//   numerator and denominator. The output channel (out_valid / out_ready)
//   returns one beat per input beat: out_valid_res, out_float_bits, out_exact.
//   A zero operand returns a beat with all result fields zero.
// Operation:
//   Both operands are first normalized one bit per cycle until their top
//   bits are set, then a radix-2 restoring divider produces one quotient
//   bit per cycle after a first step that may only drop a leading zero,
//   and a final step rounds; a zero operand goes straight to rounding.
//   One item is worked on at a time; in_ready is high only while the
//   block is idle.
// Reset and stalls:
//   rst_n is synchronous, active low, and returns the block to idle with no
//   pending result. A finished result waits in the output register while
//   out_ready is low; the next item may already be accepted and computed, and
//   it holds in its rounding step until the output register is free.
// ----------------------------------------------------------------------------
module rational_to_float32_converter_top #(
  parameter int OPERAND_BITS = rtf_pkg::OPERAND_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OPERAND_BITS-1:0]      in_numerator,
  input  logic [OPERAND_BITS-1:0]      in_denominator,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_valid_res,
  output logic [rtf_pkg::FLOAT_W-1:0]  out_float_bits,
  output logic                         out_exact
);
  import rtf_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                  state_r;
  logic [OPERAND_BITS-1:0] n_r;
  logic [OPERAND_BITS-1:0] d_r;
  logic [OPERAND_BITS:0]   rem_r;
  logic [QUO_BITS-1:0]     quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [EXP_W-1:0]        exp_r;
  logic                    started_r;
  logic                    zero_r;

  logic                    out_valid_r;
  logic                    out_valid_res_r;
  logic [FLOAT_W-1:0]      out_float_bits_r;
  logic                    out_exact_r;

  // Divider step.
  logic                    ge;
  logic [OPERAND_BITS:0]   diff;
  logic                    take_bit;

  // Normalization step.
  logic                    n_sh;
  logic                    d_sh;

  // Rounding.
  logic [SIG_BITS-1:0]     sig;
  logic                    guard;
  logic                    sticky;
  logic                    round_up;
  logic                    carry;
  logic [FRAC_BITS-1:0]    frac_rnd;
  logic [EXP_W-1:0]        exp_rnd;

  assign ge       = rem_r >= {1'b0, d_r};
  assign diff     = ge ? (rem_r - {1'b0, d_r}) : rem_r;
  // A leading zero quotient bit can only occur on the first step, when the
  // normalized numerator is below the normalized divisor.
  assign take_bit = started_r | ge;

  assign n_sh = ~n_r[OPERAND_BITS-1];
  assign d_sh = ~d_r[OPERAND_BITS-1];

  assign sig      = quo_r[QUO_BITS-1:1];
  assign guard    = quo_r[0];
  assign sticky   = rem_r != '0;
  assign round_up = guard & (sticky | sig[0]);
  assign carry    = round_up & (&sig);
  assign frac_rnd = sig[FRAC_BITS-1:0] + FRAC_BITS'(round_up);
  assign exp_rnd  = exp_r + EXP_W'(carry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The rounding step reloads the output register itself.
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            n_r       <= in_numerator;
            d_r       <= in_denominator;
            exp_r     <= EXP_W'(EXP_BIAS);
            cnt_r     <= '0;
            quo_r     <= '0;
            started_r <= 1'b0;
            zero_r    <= (in_numerator == '0) || (in_denominator == '0);
            if ((in_numerator == '0) || (in_denominator == '0)) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (!n_sh && !d_sh) begin
            rem_r   <= {1'b0, n_r};
            state_r <= ST_DIV;
          end else begin
            // Each numerator shift lowers the exponent, each divisor shift
            // raises it.
            if (n_sh) begin
              n_r <= {n_r[OPERAND_BITS-2:0], 1'b0};
            end
            if (d_sh) begin
              d_r <= {d_r[OPERAND_BITS-2:0], 1'b0};
            end
            exp_r <= exp_r + EXP_W'(d_sh) - EXP_W'(n_sh);
          end
        end
        ST_DIV: begin
          started_r <= 1'b1;
          rem_r     <= {diff[OPERAND_BITS-1:0], 1'b0};
          if (!take_bit) begin
            exp_r <= exp_r - EXP_W'(1);
          end else begin
            quo_r <= {quo_r[QUO_BITS-2:0], ge};
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(QUO_BITS - 1)) begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (zero_r) begin
              out_valid_res_r  <= 1'b0;
              out_float_bits_r <= '0;
              out_exact_r      <= 1'b0;
            end else begin
              out_valid_res_r  <= 1'b1;
              out_float_bits_r <= {1'b0, exp_rnd, frac_rnd};
              out_exact_r      <= ~guard & ~sticky;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = state_r == ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_valid_res_r;
  assign out_float_bits = out_float_bits_r;
  assign out_exact      = out_exact_r;

  // The divider only runs on a normalized divisor with a partial remainder
  // below twice the divisor.
  `ASSERT_IMP(a_div_norm, clk, rst_n, state_r == ST_DIV,
    d_r[OPERAND_BITS-1] && (rem_r < {d_r, 1'b0}), "divider operands not normalized")
  // A valid result is positive and never denormal.
  `ASSERT_IMP(a_res_form, clk, rst_n, out_valid_r && out_valid_res_r,
    !out_float_bits_r[FLOAT_W-1] && (out_float_bits_r[FLOAT_W-2:FRAC_BITS] != '0),
    "malformed binary32 result")
  // A rejected item carries all-zero result fields.
  `ASSERT_IMP(a_rej_zero, clk, rst_n, out_valid_r && !out_valid_res_r,
    (out_float_bits_r == '0) && !out_exact_r, "rejected result not cleared")
  // Finishing always loads the output register when it is free.
  `ASSERT_NEXT(a_fin_load, clk, rst_n, (state_r == ST_FIN) && !out_valid_r,
    out_valid_r && (state_r == ST_IDLE), "finished result not delivered")

endmodule

FILE: dv/rational_to_float32_converter_top_test.sv
// ----------------------------------------------------------------------------
// rational_to_float32_converter_top_test
// Drives numerator / denominator beats into the converter and checks every
// binary32 result beat, in order, against a predictor built on long division
// with round to nearest even. Both channels idle in random bursts, and the
// closing stretch of the run streams with no idling at all.
// ----------------------------------------------------------------------------
module rational_to_float32_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        valid_res;
    bit [31:0] float_bits;
    bit        exact;
  } float_beat_t;

  class float_result_board;
    float_beat_t awaited_floats[$];
    int mismatches;
    int ratios_in;
    int converted;
    int exact_hits;
    int rejected;

    // Nearest binary32 of num / den, found by restoring long division.
    function float_beat_t nearest_binary32(bit [31:0] num, bit [31:0] den);
      float_beat_t res;
      bit [63:0]   quo;
      bit [63:0]   rem;
      bit [63:0]   div;
      bit [63:0]   scaled;
      int          expo;
      int          shift;
      int          k;
      bit          no_rem;
      res = '0;
      if (num == 0 || den == 0) return res;
      expo = 0;
      if (num >= den) begin
        quo = num / den;
        while (quo > 1) begin
          quo = quo >> 1;
          expo++;
        end
      end else begin
        scaled = num;
        while (scaled < den) begin
          scaled = scaled << 1;
          expo--;
        end
      end
      shift = rtf_pkg::FRAC_BITS - expo;
      div = den;
      if (shift >= 0) begin
        quo = num / div;
        rem = num % div;
        for (k = 0; k < shift; k++) begin
          quo = quo << 1;
          rem = rem << 1;
          if (rem >= div) begin
            quo++;
            rem -= div;
          end
        end
      end else begin
        if (-shift >= 32) return res;
        div = div << (-shift);
        quo = num / div;
        rem = num % div;
      end
      no_rem = (rem == 0);
      if ((rem << 1) > div || ((rem << 1) == div && quo[0])) quo++;
      // A carry out of the significand renormalizes one place.
      if (quo == (64'd1 << rtf_pkg::SIG_BITS)) begin
        quo = quo >> 1;
        expo++;
      end
      if (expo < -126 || expo > 127 || quo < (64'd1 << rtf_pkg::FRAC_BITS) ||
          quo >= (64'd1 << rtf_pkg::SIG_BITS)) return res;
      res.valid_res  = 1'b1;
      res.float_bits = {1'b0, 8'(expo + rtf_pkg::EXP_BIAS),
                        quo[rtf_pkg::FRAC_BITS-1:0]};
      res.exact      = no_rem;
      return res;
    endfunction

    function void note_ratio(bit [31:0] num, bit [31:0] den);
      float_beat_t want;
      want = nearest_binary32(num, den);
      awaited_floats.push_back(want);
      ratios_in++;
      if (!want.valid_res) rejected++;
      else begin
        converted++;
        if (want.exact) exact_hits++;
      end
    endfunction

    function void check_beat(logic vr, logic [31:0] fb, logic ex);
      float_beat_t want;
      if (awaited_floats.size() == 0) begin
        $display("%0t: result beat with nothing expected (valid_res %b bits %h exact %b)",
                 $time, vr, fb, ex);
        mismatches++;
        return;
      end
      want = awaited_floats.pop_front();
      if (vr !== want.valid_res) begin
        $display("%0t: out_valid_res expected %b got %b", $time, want.valid_res, vr);
        mismatches++;
      end
      if (fb !== want.float_bits) begin
        $display("%0t: out_float_bits expected %h got %h", $time, want.float_bits, fb);
        mismatches++;
      end
      if (ex !== want.exact) begin
        $display("%0t: out_exact expected %b got %b", $time, want.exact, ex);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_floats.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_numerator = '0;
  logic [31:0] in_denominator = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_valid_res;
  logic [31:0] out_float_bits;
  logic        out_exact;

  bit steady = 1'b0;
  float_result_board board = new();

  rational_to_float32_converter_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_numerator   (in_numerator),
    .in_denominator (in_denominator),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_valid_res  (out_valid_res),
    .out_float_bits (out_float_bits),
    .out_exact      (out_exact)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one ratio after an optional idle gap and waits for it to be taken.
  task automatic send_ratio(bit [31:0] num, bit [31:0] den, int gap);
    for (int k = 0; k < gap; k++) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_numerator   <= num;
    in_denominator <= den;
    do @(posedge clk); while (!in_ready);
    board.note_ratio(num, den);
  endtask

  function automatic int idle_burst();
    if (steady || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  // Operand of random bit length, so that quotients span the exponent range.
  function automatic bit [31:0] any_length_operand();
    int len;
    len = $urandom_range(0, 32);
    if (len == 0) return '0;
    return ($urandom() | (32'h1 << (len - 1))) & (32'hFFFF_FFFF >> (32 - len));
  endfunction

  task automatic drain_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_beat(out_valid_res, out_float_bits, out_exact);
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    bit [31:0] dir_num [23] = '{
      32'h0, 32'h0, 32'h9, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'h8000_0000, 32'h1, 32'h8, 32'h1, 32'h2, 32'h7,
      32'h0200_0001, 32'h0200_0002, 32'h0200_0006, 32'h01FF_FFFF, 32'h00FF_FFFF,
      32'h7FFF_FFFF, 32'h5, 32'h3};
    bit [31:0] dir_den [23] = '{
      32'h0, 32'h7, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h2, 32'h3, 32'h3, 32'h3,
      32'h1, 32'h1, 32'h1, 32'h1, 32'h1,
      32'h8000_0000, 32'h5, 32'h2};
    bit [31:0] num;
    bit [31:0] den;
    int        pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero operands, extremes, exact powers, ties to even both ways and a
    // rounding carry that renormalizes the significand.
    foreach (dir_num[k]) send_ratio(dir_num[k], dir_den[k], idle_burst());

    for (int i = 0; i < 700; i++) begin
      steady = (i >= 600);
      if (i == 350) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        num = any_length_operand();
        den = any_length_operand();
      end else if (pick < 75) begin
        num = $urandom();
        den = $urandom();
      end else if (pick < 90) begin
        // Power-of-two divisors leave remainders that often sit on a tie.
        num = $urandom();
        den = 32'h1 << $urandom_range(0, 8);
      end else begin
        den = any_length_operand();
        num = 32'(den * $urandom_range(1, 4) + $urandom_range(0, 2));
      end
      send_ratio(num, den, idle_burst());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    drain_results();
    repeat (70) @(posedge clk);
    $display("Sent %0d ratios: %0d converted (%0d exact), %0d rejected for a zero operand.",
             board.ratios_in, board.converted, board.exact_hits, board.rejected);
    $display("Covered operand extremes, ties to even, rounding carries and idle on both sides.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results still awaited.", board.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
